/* hdl/nlvg_pkg.sv */
// Shared constants and types for the nearest later value gap block.
`timescale 1ns / 1ps
package nlvg_pkg;

  localparam int VAL_W           = 32;
  localparam int MAX_ITEMS_DEF   = 64;

  typedef struct packed {
    logic clear;
    logic step;
  } nlvg_ctl_t;

endpackage

/* hdl/nlvg_absmin.sv */
// Shared absolute-difference and running-minimum unit.
`timescale 1ns / 1ps
module nlvg_absmin (
  input  logic                      clk,
  input  nlvg_pkg::nlvg_ctl_t       ctl,
  input  logic [nlvg_pkg::VAL_W-1:0] here,
  input  logic [nlvg_pkg::VAL_W-1:0] other,
  output logic [nlvg_pkg::VAL_W-1:0] best
);
  import nlvg_pkg::*;

  logic signed [VAL_W:0] diff;
  logic        [VAL_W:0] mag;
  logic [VAL_W-1:0]      best_r;
  logic [VAL_W-1:0]      best_nxt;

  always_comb begin
    diff = $signed({other[VAL_W-1], other}) - $signed({here[VAL_W-1], here});
    mag  = diff[VAL_W] ? (~diff + 1'b1) : diff;
    best_nxt = best_r;
    if (ctl.clear) begin
      best_nxt = '1;
    end else if (ctl.step && (mag[VAL_W-1:0] < best_r)) begin
      best_nxt = mag[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    best_r <= best_nxt;
  end

  assign best = best_r;

endmodule

/* hdl/nearest_later_value_gap.sv */
// Top level: value store, scan sequencer and result register.
// Loading accepts one beat per cycle; in_tready is high while loading.
// A run of n stored values is scanned per position j < n-1 against each later
// value (n-1-j of them) in turn, through the single store read port and the
// shared abs/min unit; a stall on out_tready holds the scan.
// Reset (rst_n low, synchronous) empties the store and clears the output.
`timescale 1ns / 1ps
module nearest_later_value_gap #(
  parameter int MAX_ITEMS = nlvg_pkg::MAX_ITEMS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic        in_tlast,   // is_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] gap
  output logic        out_tlast   // last_result
);
  import nlvg_pkg::*;

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);

  localparam logic [1:0] S_LOAD  = 2'd0;
  localparam logic [1:0] S_FIRST = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [VAL_W-1:0] mem [MAX_ITEMS];
  logic [VAL_W-1:0] rd_data_r;
  logic [AW-1:0]    rd_addr;

  logic [1:0]       state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]    j_r, j_nxt;
  logic [CW-1:0]    k_r, k_nxt;
  logic [VAL_W-1:0] here_r, here_nxt;
  logic             oval_r, oval_nxt;
  logic [VAL_W-1:0] odat_r, odat_nxt;
  logic             olast_r, olast_nxt;

  logic             in_acc;
  logic             wr_en;
  logic [CW-1:0]    n_after;
  logic             final_pos;
  logic             oslot;
  nlvg_ctl_t        ctl;
  logic [VAL_W-1:0] best;

  assign in_tready = (state_r == S_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign wr_en     = in_acc && (cnt_r < CW'(MAX_ITEMS));
  assign n_after   = wr_en ? (cnt_r + 1'b1) : cnt_r;
  assign final_pos = (({1'b0, j_r} + (CW + 1)'(2)) == {1'b0, cnt_r});
  assign oslot     = !oval_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    here_nxt  = here_r;
    oval_nxt  = oval_r && !out_tready;
    odat_nxt  = odat_r;
    olast_nxt = olast_r;
    rd_addr   = j_r[AW-1:0];
    ctl       = '0;
    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          cnt_nxt = n_after;
          if (in_tlast) begin
            if (n_after >= CW'(2)) begin
              j_nxt     = '0;
              k_nxt     = CW'(1);
              rd_addr   = '0;
              state_nxt = S_FIRST;
            end else begin
              cnt_nxt = '0;
            end
          end
        end
      end
      S_FIRST: begin
        here_nxt  = rd_data_r;
        rd_addr   = k_r[AW-1:0];
        k_nxt     = k_r + 1'b1;
        ctl.clear = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        ctl.step = 1'b1;
        if (k_r == cnt_r) begin
          state_nxt = S_EMIT;
        end else begin
          rd_addr = k_r[AW-1:0];
          k_nxt   = k_r + 1'b1;
        end
      end
      S_EMIT: begin
        if (oslot) begin
          oval_nxt  = 1'b1;
          odat_nxt  = best;
          olast_nxt = final_pos;
          if (final_pos) begin
            cnt_nxt   = '0;
            state_nxt = S_LOAD;
          end else begin
            j_nxt     = j_r + 1'b1;
            k_nxt     = j_r + CW'(2);
            rd_addr   = AW'(j_r + 1'b1);
            state_nxt = S_FIRST;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt_r[AW-1:0]] <= in_tdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      oval_r  <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r     <= j_nxt;
    k_r     <= k_nxt;
    here_r  <= here_nxt;
    odat_r  <= odat_nxt;
    olast_r <= olast_nxt;
  end

  nlvg_absmin u_absmin (
    .clk   (clk),
    .ctl   (ctl),
    .here  (here_r),
    .other (rd_data_r),
    .best  (best)
  );

  assign out_tvalid = oval_r;
  assign out_tdata  = odat_r;
  assign out_tlast  = olast_r;

endmodule

/* hdl/nlvg_checker.sv */
// Port-level checks for the nearest later value gap block, with bind.
`timescale 1ns / 1ps
module nlvg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [31:0] in_tdata,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("not idle after reset");

  a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input ready before run finished");

  // offered input beat holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata) && $stable(in_tlast))
    else $error("input beat changed while stalled");

endmodule

bind nearest_later_value_gap nlvg_checker u_nlvg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
